@@ hw/rtl/bpv_pkg.sv @@
`timescale 1ns / 1ps
// bpv_pkg: payload types, status codes and the control-store program of the
// bond present value block. Depends on nothing; used by bond_present_value.

package bpv_pkg;

   // field widths of the payload
   localparam int FACE_W   = 32;
   localparam int RATE_W   = 14;
   localparam int YEARS_W  = 7;
   localparam int FREQ_W   = 4;
   localparam int PRICE_W  = 48;
   localparam int STATUS_W = 2;

   // derived fixed widths
   localparam int FC_W       = FACE_W + RATE_W;    // face * coupon rate
   localparam int DIV_W      = 18;                 // holds 10000*15 + 16383
   localparam int NRAW_W     = YEARS_W + FREQ_W;   // years * frequency
   localparam int LIMB_W     = 32;                 // multiplier operand width
   localparam int RATE_SCALE = 10000;              // hundredths of a percent

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_FREQ = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic [FACE_W-1:0]  face_cents;
      logic [RATE_W-1:0]  coupon_hundredths_pct;
      logic [RATE_W-1:0]  discount_hundredths_pct;
      logic [YEARS_W-1:0] maturity_years;
      logic [FREQ_W-1:0]  payments_per_year;
   } req_type;

   typedef struct packed {
      logic [PRICE_W-1:0]  price_cents;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // multiplier operand a: weight limbs, sum limbs, face value
   typedef enum logic [2:0] {
      OPA_W0, OPA_W1, OPA_S0, OPA_S1, OPA_S2, OPA_FACE
   } opa_type;

   // multiplier operand b: factor limbs, face*coupon limbs, coupon, weight limbs
   typedef enum logic [2:0] {
      OPB_V0, OPB_V1, OPB_FC0, OPB_FC1, OPB_CR, OPB_W0, OPB_W1
   } opb_type;

   // datapath actions besides the multiply-accumulate
   typedef enum logic [3:0] {
      ACT_NONE, ACT_SETUP, ACT_DIV, ACT_VSET, ACT_WUPD,
      ACT_FCSET, ACT_DSET, ACT_HALF, ACT_FIN
   } act_type;

   // branch conditions
   typedef enum logic [1:0] {
      BR_NONE, BR_ZERO_FREQ, BR_CNT_MORE, BR_N_ZERO
   } br_type;

   // control store addresses
   typedef enum logic [4:0] {
      S_SETUP, S_DIV_V, S_VSET,
      S_W_LL, S_W_LH, S_W_HL, S_W_HH, S_W_DRAIN, S_W_UPD,
      S_FC_MUL, S_FC_DRAIN, S_FC_SET,
      S_P_00, S_P_01, S_P_10, S_P_11, S_P_20, S_P_21, S_P_DRAIN,
      S_DIV_A, S_B_LO, S_B_HI, S_B_DRAIN, S_HALF, S_FIN
   } step_type;

   typedef struct packed {
      logic       mul_en;
      opa_type    opa;
      opb_type    opb;
      logic [1:0] shift;     // product lands shifted by this many limbs
      logic       acc_clr;
      act_type    act;
      br_type     br;
      step_type   target;
   } uword_type;

   // control store: one word per step
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{mul_en: 1'b0, opa: OPA_W0, opb: OPB_V0, shift: 2'd0, acc_clr: 1'b0,
            act: ACT_NONE, br: BR_NONE, target: S_SETUP};
      case (step)
         S_SETUP: begin
            w.act = ACT_SETUP; w.br = BR_ZERO_FREQ; w.target = S_FIN;
         end
         S_DIV_V: begin
            w.act = ACT_DIV; w.br = BR_CNT_MORE; w.target = S_DIV_V;
         end
         S_VSET: begin
            w.act = ACT_VSET; w.br = BR_N_ZERO; w.target = S_FC_MUL;
         end
         S_W_LL: begin
            w.mul_en = 1'b1; w.opa = OPA_W0; w.opb = OPB_V0; w.shift = 2'd0;
            w.acc_clr = 1'b1;
         end
         S_W_LH: begin
            w.mul_en = 1'b1; w.opa = OPA_W0; w.opb = OPB_V1; w.shift = 2'd1;
         end
         S_W_HL: begin
            w.mul_en = 1'b1; w.opa = OPA_W1; w.opb = OPB_V0; w.shift = 2'd1;
         end
         S_W_HH: begin
            w.mul_en = 1'b1; w.opa = OPA_W1; w.opb = OPB_V1; w.shift = 2'd2;
         end
         S_W_DRAIN: begin
            w.act = ACT_NONE;
         end
         S_W_UPD: begin
            w.act = ACT_WUPD; w.br = BR_CNT_MORE; w.target = S_W_LL;
         end
         S_FC_MUL: begin
            w.mul_en = 1'b1; w.opa = OPA_FACE; w.opb = OPB_CR; w.shift = 2'd0;
            w.acc_clr = 1'b1;
         end
         S_FC_DRAIN: begin
            w.act = ACT_NONE;
         end
         S_FC_SET: begin
            w.act = ACT_FCSET;
         end
         S_P_00: begin
            w.mul_en = 1'b1; w.opa = OPA_S0; w.opb = OPB_FC0; w.shift = 2'd0;
            w.acc_clr = 1'b1;
         end
         S_P_01: begin
            w.mul_en = 1'b1; w.opa = OPA_S0; w.opb = OPB_FC1; w.shift = 2'd1;
         end
         S_P_10: begin
            w.mul_en = 1'b1; w.opa = OPA_S1; w.opb = OPB_FC0; w.shift = 2'd1;
         end
         S_P_11: begin
            w.mul_en = 1'b1; w.opa = OPA_S1; w.opb = OPB_FC1; w.shift = 2'd2;
         end
         S_P_20: begin
            w.mul_en = 1'b1; w.opa = OPA_S2; w.opb = OPB_FC0; w.shift = 2'd2;
         end
         S_P_21: begin
            w.mul_en = 1'b1; w.opa = OPA_S2; w.opb = OPB_FC1; w.shift = 2'd3;
         end
         S_P_DRAIN: begin
            w.act = ACT_DSET;
         end
         S_DIV_A: begin
            w.act = ACT_DIV; w.br = BR_CNT_MORE; w.target = S_DIV_A;
         end
         S_B_LO: begin
            w.mul_en = 1'b1; w.opa = OPA_FACE; w.opb = OPB_W0; w.shift = 2'd0;
         end
         S_B_HI: begin
            w.mul_en = 1'b1; w.opa = OPA_FACE; w.opb = OPB_W1; w.shift = 2'd1;
         end
         S_B_DRAIN: begin
            w.act = ACT_NONE;
         end
         S_HALF: begin
            w.act = ACT_HALF;
         end
         S_FIN: begin
            w.act = ACT_FIN;
         end
         default: begin
            w.act = ACT_FIN;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/bond_present_value.sv @@
`timescale 1ns / 1ps
// bond_present_value: microcoded fixed-point present value of a coupon bond.
// Depends on bpv_pkg for payload types, status codes and the control store.

// One bond is priced at a time. A 25-word control store sequences a single
// 32x32 multiplier with a registered product, a wide accumulator, and a
// one-bit-per-cycle restoring divider with an 18-bit divisor. The accumulator
// is ACC_W = max(FRAC_BITS+1+clog2(MAX_PERIODS+1)+46, 2*FRAC_BITS+2) + 1 bits
// wide (107 at the default parameters), and each of the two divisions steps
// over all ACC_W bits. The weight loop (four partial products, one drain, one
// update) runs n = min(years * payments, MAX_PERIODS) times and dominates for
// long bonds; the two divisions dominate for short ones. A zero payment
// frequency goes from setup straight to the finishing step with status 1.
// The next bond is taken as soon as the sequencer is free, while a finished
// price may still wait in the output register.

module bond_present_value #(
   parameter int MAX_PERIODS = 1200,
   parameter int FRAC_BITS   = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpv_pkg::rsp_type rsp_data
);

   import bpv_pkg::*;

   localparam int WW      = FRAC_BITS + 1;
   localparam int SW      = WW + $clog2(MAX_PERIODS + 1);
   localparam int ACC_A   = SW + FC_W;
   localparam int ACC_W   = ((ACC_A > 2 * WW) ? ACC_A : 2 * WW) + 1;
   localparam int NRAW_MX = (1 << NRAW_W) - 1;
   localparam int CNT_M1  = (ACC_W > MAX_PERIODS) ? ACC_W : MAX_PERIODS;
   localparam int CNT_MAX = (CNT_M1 > NRAW_MX) ? CNT_M1 : NRAW_MX;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);
   localparam int EXT_W   = ACC_W + 3 * LIMB_W;

   // control state
   logic                busy_ff, busy_in;
   step_type            pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                prod_vld_ff, prod_vld_in;
   // datapath
   rsp_type             rsp_data_ff, rsp_data_in;
   req_type             item_ff, item_in;
   logic [1:0]          prod_sh_ff, prod_sh_in;
   logic [2*LIMB_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [WW-1:0]       w_ff, w_in;
   logic [WW-1:0]       v_ff, v_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [FC_W-1:0]     fc_ff, fc_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   uword_type           uw;
   logic                accept;
   logic                fin_go;
   logic                taken;
   logic [DIV_W-1:0]    d_val;
   logic [DIV_W-1:0]    den_val;
   logic [NRAW_W-1:0]   n_raw;
   logic                n_over;
   logic [2*LIMB_W-1:0] w_pad, v_pad, fc_pad;
   logic [3*LIMB_W-1:0] s_pad;
   logic [LIMB_W-1:0]   mul_a, mul_b;
   logic [EXT_W-1:0]    prod_ext;
   logic [ACC_W-1:0]    landing;
   logic [DIV_W:0]      div_t;
   logic                div_ge;
   logic [DIV_W-1:0]    div_rem;
   logic [WW-1:0]       w_next;
   logic                over;

   assign uw        = ucode(pc_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign fin_go    = busy_ff && (uw.act == ACT_FIN) && (!rsp_valid_ff || rsp_ready);

   // per-bond constants
   assign d_val   = DIV_W'(item_ff.payments_per_year) * DIV_W'(RATE_SCALE);
   assign den_val = d_val + DIV_W'(item_ff.discount_hundredths_pct);
   assign n_raw   = NRAW_W'(item_ff.maturity_years) * NRAW_W'(item_ff.payments_per_year);
   assign n_over  = CNT_W'(n_raw) > CNT_W'(MAX_PERIODS);

   // multiplier operand limbs
   assign w_pad  = (2 * LIMB_W)'(w_ff);
   assign v_pad  = (2 * LIMB_W)'(v_ff);
   assign fc_pad = (2 * LIMB_W)'(fc_ff);
   assign s_pad  = (3 * LIMB_W)'(s_ff);

   always_comb begin
      case (uw.opa)
         OPA_W0:  mul_a = w_pad[LIMB_W-1:0];
         OPA_W1:  mul_a = w_pad[2*LIMB_W-1:LIMB_W];
         OPA_S0:  mul_a = s_pad[LIMB_W-1:0];
         OPA_S1:  mul_a = s_pad[2*LIMB_W-1:LIMB_W];
         OPA_S2:  mul_a = s_pad[3*LIMB_W-1:2*LIMB_W];
         default: mul_a = item_ff.face_cents;
      endcase
   end

   always_comb begin
      case (uw.opb)
         OPB_V0:  mul_b = v_pad[LIMB_W-1:0];
         OPB_V1:  mul_b = v_pad[2*LIMB_W-1:LIMB_W];
         OPB_FC0: mul_b = fc_pad[LIMB_W-1:0];
         OPB_FC1: mul_b = fc_pad[2*LIMB_W-1:LIMB_W];
         OPB_CR:  mul_b = LIMB_W'(item_ff.coupon_hundredths_pct);
         OPB_W0:  mul_b = w_pad[LIMB_W-1:0];
         default: mul_b = w_pad[2*LIMB_W-1:LIMB_W];
      endcase
   end

   // one 32x32 multiply per cycle, product registered
   assign prod_in = (2 * LIMB_W)'(mul_a) * (2 * LIMB_W)'(mul_b);

   // registered product lands in the accumulator in the following cycle
   assign prod_ext = EXT_W'(prod_ff) << (LIMB_W * prod_sh_ff);
   assign landing  = prod_vld_ff ? ACC_W'(prod_ext) : '0;

   // restoring divide step: accumulator msb into remainder, quotient into lsb
   assign div_t   = {rem_ff, acc_ff[ACC_W-1]};
   assign div_ge  = div_t >= {1'b0, div_ff};
   assign div_rem = div_ge ? DIV_W'(div_t - {1'b0, div_ff}) : DIV_W'(div_t);

   assign w_next = acc_ff[FRAC_BITS +: WW];
   assign over   = |(acc_ff >> (FRAC_BITS + PRICE_W));

   // branch condition
   always_comb begin
      case (uw.br)
         BR_ZERO_FREQ: taken = item_ff.payments_per_year == '0;
         BR_CNT_MORE:  taken = cnt_ff != CNT_W'(1);
         BR_N_ZERO:    taken = n_ff == '0;
         default:      taken = 1'b0;
      endcase
   end

   // next state of sequencer and datapath
   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      item_in      = item_ff;
      prod_vld_in  = busy_ff && uw.mul_en;
      prod_sh_in   = uw.shift;
      acc_in       = ((busy_ff && uw.acc_clr) ? '0 : acc_ff) + landing;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      w_in         = w_ff;
      v_in         = v_ff;
      s_in         = s_ff;
      fc_in        = fc_ff;
      status_in    = status_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in = 1'b1;
         pc_in   = S_SETUP;
         item_in = req_data;
      end else if (busy_ff) begin
         // datapath action of the current step
         case (uw.act)
            ACT_SETUP: begin
               if (item_ff.payments_per_year == '0) begin
                  status_in = STATUS_ZERO_FREQ;
               end else if (n_over) begin
                  status_in = STATUS_SATURATED;
               end else begin
                  status_in = STATUS_OK;
               end
               acc_in = ACC_W'(d_val) << FRAC_BITS;
               div_in = den_val;
               rem_in = '0;
               cnt_in = CNT_W'(ACC_W);
               n_in   = n_over ? CNT_W'(MAX_PERIODS) : CNT_W'(n_raw);
               w_in   = WW'(1) << FRAC_BITS;
               s_in   = '0;
            end
            ACT_DIV: begin
               acc_in = {acc_ff[ACC_W-2:0], div_ge};
               rem_in = div_rem;
               cnt_in = cnt_ff - CNT_W'(1);
            end
            ACT_VSET: begin
               v_in   = acc_ff[WW-1:0];
               cnt_in = n_ff;
            end
            ACT_WUPD: begin
               w_in   = w_next;
               s_in   = s_ff + SW'(w_next);
               cnt_in = cnt_ff - CNT_W'(1);
            end
            ACT_FCSET: begin
               fc_in = acc_ff[FC_W-1:0];
            end
            ACT_DSET: begin
               div_in = d_val;
               rem_in = '0;
               cnt_in = CNT_W'(ACC_W);
            end
            ACT_HALF: begin
               acc_in = acc_ff + (ACC_W'(1) << (FRAC_BITS - 1));
            end
            ACT_FIN: begin
               if (fin_go) begin
                  rsp_valid_in = 1'b1;
                  if (status_ff == STATUS_ZERO_FREQ) begin
                     rsp_data_in.price_cents = '0;
                     rsp_data_in.status      = STATUS_ZERO_FREQ;
                  end else if (over) begin
                     rsp_data_in.price_cents = '1;
                     rsp_data_in.status      = STATUS_SATURATED;
                  end else begin
                     rsp_data_in.price_cents = acc_ff[FRAC_BITS +: PRICE_W];
                     rsp_data_in.status      = status_ff;
                  end
               end
            end
            default: begin
               acc_in = acc_in;
            end
         endcase

         // step sequencing
         if (uw.act == ACT_FIN) begin
            if (fin_go) begin
               busy_in = 1'b0;
               pc_in   = S_SETUP;
            end
         end else if (taken) begin
            pc_in = uw.target;
         end else begin
            pc_in = step_type'(pc_ff + 5'd1);
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= S_SETUP;
         rsp_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         prod_vld_ff  <= prod_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      prod_sh_ff  <= prod_sh_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      w_ff        <= w_in;
      v_ff        <= v_in;
      s_ff        <= s_in;
      fc_ff       <= fc_in;
      status_ff   <= status_in;
   end

   // finishing step always leaves a result and frees the sequencer
   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (rsp_valid_ff && !busy_ff))
      else $error("finished item did not reach the output register");

   // a step that clears the accumulator must not drop a landing product
   a_clear_no_landing: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uw.acc_clr) |-> !prod_vld_ff)
      else $error("product lost on accumulator clear");

   // divider never runs with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uw.act == ACT_DIV) |-> (div_ff != '0))
      else $error("division by zero in sequencer");

   // discount weights never grow above one
   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uw.act == ACT_WUPD) |-> (w_next <= (WW'(1) << FRAC_BITS)))
      else $error("discount weight above one");

   // zero frequency always reports a zero price
   a_zero_freq_price: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_ZERO_FREQ)
         |-> (rsp_data_ff.price_cents == '0))
      else $error("zero frequency result with nonzero price");

endmodule

@@ tb/bond_present_value_tb.sv @@
`timescale 1ns / 1ps
// bond_present_value_tb: self-checking testbench for the bond present value block.
// Depends on bpv_pkg and bond_present_value; prices every bond with its own predictor.

module bond_present_value_tb;
   import bpv_pkg::*;

   localparam int MAX_PERIODS   = 1200;
   localparam int FRAC_BITS     = 48;
   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_BONDS  = 420;
   localparam int STALL_LIMIT   = 60000;   // exceeds the longest bond and the long hold
   localparam int SETTLE_CYCLES = 300;
   localparam int RATE_MAX      = (1 << RATE_W) - 1;
   localparam int YEARS_MAX     = (1 << YEARS_W) - 1;
   localparam int FREQ_MAX      = (1 << FREQ_W) - 1;

   typedef logic [191:0] wide_value_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_prices[$];
   int      mismatch_count  = 0;
   int      rsp_hold_cycles = 0;
   int      quiet_cycles    = 0;

   bond_present_value #(
      .MAX_PERIODS(MAX_PERIODS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // predicted price: discount weights by fixed-point factor, then coupon and face parts
   function automatic rsp_type price_bond(input req_type bond);
      rsp_type        price;
      wide_value_type denom_base, denom, factor, weight, weight_sum;
      wide_value_type coupon_part, face_part, total;
      int unsigned    periods;
      price.status = STATUS_OK;
      if (bond.payments_per_year == '0) begin
         price.price_cents = '0;
         price.status = STATUS_ZERO_FREQ;
         return price;
      end
      denom_base = wide_value_type'(bond.payments_per_year) * wide_value_type'(RATE_SCALE);
      denom = denom_base + wide_value_type'(bond.discount_hundredths_pct);
      factor = (denom_base << FRAC_BITS) / denom;
      periods = bond.maturity_years * bond.payments_per_year;
      if (periods > MAX_PERIODS) begin
         periods = MAX_PERIODS;
         price.status = STATUS_SATURATED;
      end
      weight = wide_value_type'(1) << FRAC_BITS;
      weight_sum = '0;
      for (int unsigned i = 0; i < periods; i++) begin
         weight = (weight * factor) >> FRAC_BITS;
         weight_sum = weight_sum + weight;
      end
      coupon_part = (weight_sum * (wide_value_type'(bond.face_cents)
                     * wide_value_type'(bond.coupon_hundredths_pct))) / denom_base;
      face_part = wide_value_type'(bond.face_cents) * weight;
      total = (coupon_part + face_part + (wide_value_type'(1) << (FRAC_BITS - 1)))
              >> FRAC_BITS;
      if (total > wide_value_type'({PRICE_W{1'b1}})) begin
         price.price_cents = {PRICE_W{1'b1}};
         price.status = STATUS_SATURATED;
      end else begin
         price.price_cents = total[PRICE_W-1:0];
      end
      return price;
   endfunction

   function automatic req_type make_bond(input logic [FACE_W-1:0] face, input int coupon,
                                         input int discount, input int years, input int freq);
      req_type bond;
      bond.face_cents = face;
      bond.coupon_hundredths_pct = RATE_W'(coupon);
      bond.discount_hundredths_pct = RATE_W'(discount);
      bond.maturity_years = YEARS_W'(years);
      bond.payments_per_year = FREQ_W'(freq);
      return bond;
   endfunction

   // mostly short bonds, some medium, a few up to the full field range
   function automatic req_type random_bond();
      req_type     bond;
      int unsigned mode;
      mode = $urandom_range(0, 99);
      bond.face_cents = ($urandom_range(0, 4) == 0) ? FACE_W'($urandom_range(0, 1000000))
                                                    : FACE_W'($urandom);
      bond.coupon_hundredths_pct = ($urandom_range(0, 9) < 7) ?
         RATE_W'($urandom_range(0, RATE_SCALE)) : RATE_W'($urandom_range(0, RATE_MAX));
      bond.discount_hundredths_pct = ($urandom_range(0, 9) < 7) ?
         RATE_W'($urandom_range(0, RATE_SCALE)) : RATE_W'($urandom_range(0, RATE_MAX));
      if (mode < 80) begin
         bond.maturity_years = YEARS_W'($urandom_range(0, 5));
         bond.payments_per_year = FREQ_W'($urandom_range(0, FREQ_MAX));
      end else if (mode < 95) begin
         bond.maturity_years = YEARS_W'($urandom_range(0, 40));
         bond.payments_per_year = FREQ_W'($urandom_range(0, 4));
      end else begin
         bond.maturity_years = YEARS_W'($urandom_range(0, YEARS_MAX));
         bond.payments_per_year = FREQ_W'($urandom_range(0, FREQ_MAX));
      end
      return bond;
   endfunction

   // offer one bond and hold it until the transfer, then queue its price
   task automatic send_bond(input req_type bond);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= bond;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_prices.push_back(price_bond(bond));
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_priced();
      sender_gap(1);
      while (expected_prices.size() != 0) @(posedge clock);
   endtask

   // extremes of the fields and the special cases
   task automatic test_corner_bonds();
      send_bond(make_bond('0, 0, 0, 0, 0));
      send_bond(make_bond('1, RATE_MAX, RATE_MAX, YEARS_MAX, 0));
      send_bond(make_bond(32'd123456789, 500, 700, 0, 2));
      send_bond(make_bond('1, RATE_MAX, 0, 0, FREQ_MAX));
      send_bond(make_bond(32'd100000, 500, 0, 10, 2));
      send_bond(make_bond('1, RATE_MAX, 0, 100, 12));
      sender_gap(5);
      send_bond(make_bond(32'd5000000, RATE_MAX, RATE_MAX, 3, 4));
      send_bond(make_bond(32'd100000, RATE_SCALE, RATE_SCALE, 5, 1));
      send_bond(make_bond('1, RATE_MAX, 0, 101, 12));
      send_bond(make_bond(32'hA5A5A5A5, 10001, 12000, YEARS_MAX, FREQ_MAX));
      send_bond(make_bond(32'h5A5A5A5A, 450, 380, 109, 11));
      send_bond(make_bond('1, RATE_MAX, RATE_MAX, YEARS_MAX, FREQ_MAX));
      sender_gap(17);
      send_bond(make_bond(32'd1, 1, 1, 1, 1));
      send_bond(make_bond(32'd250000, 625, 590, 1, FREQ_MAX));
      send_bond(make_bond(32'd99999, 300, 0, 7, 8));
      send_bond(make_bond('0, RATE_MAX, 400, 12, 2));
      send_bond(make_bond(32'd1000000, 0, 550, 30, 2));
      send_bond(make_bond(32'd1000000, 800, 1, 4, 13));
      send_bond(make_bond(32'h80000000, 8192, 8192, 64, 8));
      send_bond(make_bond(32'd7777777, 1, RATE_MAX, 2, 14));
      wait_all_priced();
   endtask

   // random bonds in bursts, with an occasional full drain
   task automatic test_random_bonds(input int count);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         send_bond(random_bond());
         burst_left--;
         if (i % 100 == 99) begin
            wait_all_priced();
         end else if (burst_left == 0) begin
            sender_gap($urandom_range(0, 30));
            burst_left = $urandom_range(1, 40);
         end
      end
      wait_all_priced();
   endtask

   // receiver holds off while bonds keep coming, so the input stalls
   task automatic test_output_hold();
      rsp_hold_cycles = 3000;
      for (int i = 0; i < 10; i++) begin
         send_bond(make_bond(FACE_W'($urandom), $urandom_range(0, RATE_SCALE),
                             $urandom_range(0, RATE_SCALE), $urandom_range(0, 2),
                             $urandom_range(0, 3)));
      end
      wait_all_priced();
   endtask

   // stimulus and end of run
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_corner_bonds();
      test_output_hold();
      test_random_bonds(RANDOM_BONDS);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_prices.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // receiver: stall rate is redrawn each phase, plus long holds on request
   initial begin
      int hold_left;
      int stall_pct;
      int phase_cycles;
      hold_left = 0;
      stall_pct = 0;
      phase_cycles = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            hold_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (phase_cycles == 0) begin
            case ($urandom_range(0, 4))
               0, 1: begin
                  stall_pct = 0;
               end
               2: begin
                  stall_pct = 20;
               end
               3: begin
                  stall_pct = 50;
               end
               default: begin
                  stall_pct = 85;
               end
            endcase
            phase_cycles = 64;
         end
         phase_cycles--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // compare each result transfer with the oldest predicted price
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_prices.size() == 0) begin
            $display("%0t: unexpected result price %0d status %0d", $realtime,
                     rsp_data.price_cents, rsp_data.status);
            mismatch_count++;
         end else begin
            want = expected_prices.pop_front();
            if (rsp_data.price_cents !== want.price_cents) begin
               $display("%0t: price_cents expected %0d actual %0d", $realtime,
                        want.price_cents, rsp_data.price_cents);
               mismatch_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_data.status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule
